// ----- rtl/txrsa_pkg.sv -----
`timescale 1ns / 1ps
package txrsa_pkg;

	// Ring geometry and table limits
	localparam int PAGE_BYTES      = 4096;
	localparam int HEADER_BYTES    = 16;
	localparam int MAX_PAGES       = 16;
	localparam int MAX_OUTSTANDING = 256;

	localparam int PAGE_W  = $clog2(PAGE_BYTES);
	localparam int RING_W  = $clog2(MAX_PAGES * PAGE_BYTES);
	localparam int PIDX_W  = RING_W - PAGE_W;
	localparam int PAGES_W = $clog2(MAX_PAGES + 1);

	// Field widths
	localparam int LEN_W    = 13;
	localparam int OFS_W    = 16;
	localparam int PAD_W    = 13;
	localparam int USED_W   = 14;
	localparam int FREE_W   = 17;
	localparam int STATUS_W = 2;

	// Register port
	localparam int CFG_AW  = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = CFG_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_RING_PAGES = REG_IDX_W'(0);

	localparam logic [FREE_W-1:0] RESET_FREE =
		FREE_W'(MAX_PAGES * PAGE_BYTES - HEADER_BYTES);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_REJECT   = 2'd3
	} status_t;

	typedef enum logic {
		CMD_TX      = 1'b0,
		CMD_RELEASE = 1'b1
	} command_t;

	typedef struct packed {
		logic               reinit;
		logic [PAGES_W-1:0] new_pages;
		logic [PAGES_W-1:0] pages;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic place;
		logic commit;
	} ctrl_cmd_t;

endpackage

// ----- rtl/txrsa_cfg_regs.sv -----
`timescale 1ns / 1ps
module txrsa_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [txrsa_pkg::CFG_AW-1:0]  paddr,
	input  logic [txrsa_pkg::PDATA_W-1:0] pwdata,
	output logic [txrsa_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output txrsa_pkg::cfg_t               cfg
);
	import txrsa_pkg::*;

	logic [PAGES_W-1:0]   ring_pages_q;
	logic [PAGES_W-1:0]   clamped;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[CFG_AW-1:2];
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_RING_PAGES);
	assign pready  = 1'b1;

	// Clamp the page count to the supported range
	always_comb begin
		if (pwdata == '0) begin
			clamped = PAGES_W'(1);
		end else if (pwdata > PDATA_W'(MAX_PAGES)) begin
			clamped = PAGES_W'(MAX_PAGES);
		end else begin
			clamped = pwdata[PAGES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pages_q <= PAGES_W'(MAX_PAGES);
		end else if (wr_en) begin
			ring_pages_q <= clamped;
		end
	end

	assign prdata = (reg_idx == REG_RING_PAGES) ? PDATA_W'(ring_pages_q) : '0;

	assign cfg.reinit    = wr_en;
	assign cfg.new_pages = clamped;
	assign cfg.pages     = ring_pages_q;

endmodule

// ----- rtl/txrsa_ctrl.sv -----
`timescale 1ns / 1ps
module txrsa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output txrsa_pkg::ctrl_cmd_t  cmd
);
	import txrsa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PLACE,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	// The result register may be refilled in the cycle its transaction leaves
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;

	assign cmd.accept = (state_q == S_IDLE) && req_valid;
	assign cmd.place  = (state_q == S_PLACE);
	assign cmd.commit = (state_q == S_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/txrsa_dp.sv -----
`timescale 1ns / 1ps
module txrsa_dp #(
	parameter int MAX_OUTSTANDING = txrsa_pkg::MAX_OUTSTANDING
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  txrsa_pkg::cfg_t                cfg,
	input  txrsa_pkg::ctrl_cmd_t           cmd,
	input  logic                           command,
	input  logic [txrsa_pkg::LEN_W-1:0]    packet_length,
	output logic [txrsa_pkg::STATUS_W-1:0] status,
	output logic [txrsa_pkg::OFS_W-1:0]    header_offset,
	output logic [txrsa_pkg::OFS_W-1:0]    data_offset,
	output logic [txrsa_pkg::PAD_W-1:0]    prepad_bytes,
	output logic [txrsa_pkg::PAD_W-1:0]    postpad_bytes,
	output logic [txrsa_pkg::OFS_W-1:0]    next_header_offset,
	output logic [txrsa_pkg::USED_W-1:0]   used_bytes,
	output logic [txrsa_pkg::FREE_W-1:0]   free_bytes
);
	import txrsa_pkg::*;

	localparam int FIFO_AW = $clog2(MAX_OUTSTANDING);
	localparam int CNT_W   = $clog2(MAX_OUTSTANDING + 1);

	// Ring state
	logic [RING_W-1:0]  cur_hdr_q;
	logic [RING_W-1:0]  old_hdr_q;
	logic [FREE_W-1:0]  free_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FIFO_AW-1:0] rd_idx_q;
	logic [FIFO_AW-1:0] wr_idx_q;

	// Size FIFO
	logic [USED_W-1:0]  fifo_mem [MAX_OUTSTANDING];
	logic [USED_W-1:0]  rdata_q;
	logic               fifo_push;

	// Latched request
	logic               command_q;
	logic [LEN_W-1:0]   len_q;

	// Placement stage
	logic               reject_s1;
	logic [RING_W-1:0]  tmp_s1;
	logic [PAD_W-1:0]   pre_s1;
	logic [PAD_W-1:0]   post_s1;
	logic [PAGES_W-1:0] ni_s1;
	logic [PAGE_W-1:0]  noff_s1;

	logic [FREE_W-1:0]  rb;
	logic [FREE_W-1:0]  hsum;
	logic [RING_W-1:0]  tmp;
	logic [PIDX_W-1:0]  idx;
	logic [PAGE_W-1:0]  off;
	logic [USED_W-1:0]  lo;
	logic [USED_W-1:0]  t_raw;
	logic [USED_W-1:0]  t;
	logic [LEN_W-1:0]   len_raw;
	logic [LEN_W-1:0]   len_a8;
	logic               reject;
	logic [PAGES_W-1:0] ni;
	logic [PAGE_W-1:0]  noff;
	logic [PAD_W-1:0]   pre;
	logic [PAD_W-1:0]   post;

	// Commit stage
	logic [USED_W-1:0]  used;
	logic [FREE_W-1:0]  dsum;
	logic [RING_W-1:0]  doff;
	logic [RING_W-1:0]  nhdr;
	logic               nospace;
	logic [USED_W-1:0]  size;
	logic [FREE_W-1:0]  rel_free;
	logic [FREE_W-1:0]  osum;
	logic [RING_W-1:0]  new_old;

	assign rb = {cfg.pages, PAGE_W'(0)};

	// Placement: header slot, payload page and padding
	assign hsum    = FREE_W'(cur_hdr_q) + FREE_W'(HEADER_BYTES);
	assign tmp     = (hsum >= rb) ? RING_W'(hsum - rb) : RING_W'(hsum);
	assign idx     = tmp[RING_W-1:PAGE_W];
	assign off     = tmp[PAGE_W-1:0];
	assign lo      = USED_W'(len_q) + USED_W'(off);
	assign t_raw   = lo + USED_W'(7);
	assign t       = {t_raw[USED_W-1:3], 3'b000};
	assign len_raw = len_q + LEN_W'(7);
	assign len_a8  = {len_raw[LEN_W-1:3], 3'b000};
	assign reject  = (len_q > LEN_W'(PAGE_BYTES - HEADER_BYTES)) ||
		(cnt_q >= CNT_W'(MAX_OUTSTANDING));

	always_comb begin
		ni   = PAGES_W'(idx);
		noff = t[PAGE_W-1:0];
		pre  = '0;
		post = PAD_W'(t - lo);
		// Next header would straddle the page: move it to the next page
		if (t > USED_W'(PAGE_BYTES - HEADER_BYTES)) begin
			ni = ni + PAGES_W'(1);
			if (t <= USED_W'(PAGE_BYTES)) begin
				noff = '0;
				post = post + PAD_W'(USED_W'(PAGE_BYTES) - t);
			end
			// Payload runs off the ring end: restart it on page zero
			if ((ni >= cfg.pages) && (noff != '0)) begin
				noff = len_a8[PAGE_W-1:0];
				ni   = '0;
				pre  = PAD_W'(PAGE_BYTES) - PAD_W'(off);
				post = PAD_W'(len_a8 - len_q);
			end
			if (ni >= cfg.pages) begin
				ni = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			command_q <= command;
			len_q     <= packet_length;
		end
		if (cmd.place) begin
			reject_s1 <= reject;
			tmp_s1    <= tmp;
			pre_s1    <= pre;
			post_s1   <= post;
			ni_s1     <= ni;
			noff_s1   <= noff;
		end
	end

	// Commit: space check for transmit, FIFO pop for release
	assign used    = USED_W'(pre_s1) + USED_W'(len_q) + USED_W'(post_s1) +
		USED_W'(HEADER_BYTES);
	assign dsum    = FREE_W'(tmp_s1) + FREE_W'(pre_s1);
	assign doff    = (dsum >= rb) ? RING_W'(dsum - rb) : RING_W'(dsum);
	assign nhdr    = {ni_s1[PIDX_W-1:0], noff_s1};
	assign nospace = FREE_W'(used) > free_q;

	assign size     = rdata_q;
	assign rel_free = free_q + FREE_W'(size);
	assign osum     = FREE_W'(old_hdr_q) + FREE_W'(size);
	assign new_old  = (osum >= rb) ? RING_W'(osum - rb) : RING_W'(osum);

	assign fifo_push = cmd.commit && (command_q == CMD_TX) && !reject_s1 && !nospace;

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_mem[wr_idx_q] <= used;
		end
		rdata_q <= fifo_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_hdr_q <= '0;
			old_hdr_q <= '0;
			free_q    <= RESET_FREE;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
		end else if (cfg.reinit) begin
			cur_hdr_q <= '0;
			old_hdr_q <= '0;
			free_q    <= {cfg.new_pages, PAGE_W'(0)} - FREE_W'(HEADER_BYTES);
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
		end else if (cmd.commit) begin
			if (command_q == CMD_RELEASE) begin
				if (cnt_q != '0) begin
					cnt_q     <= cnt_q - CNT_W'(1);
					free_q    <= rel_free;
					old_hdr_q <= new_old;
					rd_idx_q  <= (rd_idx_q == FIFO_AW'(MAX_OUTSTANDING - 1)) ?
						'0 : rd_idx_q + FIFO_AW'(1);
				end
			end else if (fifo_push) begin
				cnt_q     <= cnt_q + CNT_W'(1);
				free_q    <= free_q - FREE_W'(used);
				cur_hdr_q <= nhdr;
				wr_idx_q  <= (wr_idx_q == FIFO_AW'(MAX_OUTSTANDING - 1)) ?
					'0 : wr_idx_q + FIFO_AW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (command_q == CMD_RELEASE) begin
				data_offset   <= '0;
				prepad_bytes  <= '0;
				postpad_bytes <= '0;
				header_offset <= old_hdr_q;
				if (cnt_q == '0) begin
					status             <= ST_EMPTY;
					next_header_offset <= '0;
					used_bytes         <= '0;
					free_bytes         <= free_q;
				end else begin
					status             <= ST_OK;
					next_header_offset <= new_old;
					used_bytes         <= size;
					free_bytes         <= rel_free;
				end
			end else if (reject_s1) begin
				status             <= ST_REJECT;
				header_offset      <= cur_hdr_q;
				data_offset        <= '0;
				prepad_bytes       <= '0;
				postpad_bytes      <= '0;
				next_header_offset <= '0;
				used_bytes         <= '0;
				free_bytes         <= free_q;
			end else begin
				status             <= nospace ? ST_NO_SPACE : ST_OK;
				header_offset      <= cur_hdr_q;
				data_offset        <= doff;
				prepad_bytes       <= pre_s1;
				postpad_bytes      <= post_s1;
				next_header_offset <= nhdr;
				used_bytes         <= used;
				free_bytes         <= nospace ? free_q : free_q - FREE_W'(used);
			end
		end
	end

endmodule

// ----- rtl/tx_packet_ring_slot_allocator_top.sv -----
`timescale 1ns / 1ps
// Transmit packet ring slot allocator.
// Request channel (req_valid/req_stall): command 0 places a packet of
// packet_length payload bytes in the paged ring, command 1 releases the
// oldest committed packet. Each request yields exactly one response on the
// rsp_valid/rsp_stall channel carrying status, offsets, padding, used and
// free byte counts.
// A request is latched at its accepting edge, then placed (S_PLACE) and
// committed (S_COMMIT) into the output register, which raises rsp_valid;
// the commit also reads the used-size FIFO memory through its registered read
// port. No new request is accepted until the previous one has committed.
// A response waits in the output register while rsp_stall is high; the next
// request is still accepted and placed, and its commit holds until that
// output transaction completes.
// The APB register ring_pages (address 0) sets the ring size; a write
// reinitializes all ring state. Reset selects the full ring size, an empty
// ring and an empty FIFO, with no clearing pass.
module tx_packet_ring_slot_allocator_top #(
	parameter int MAX_OUTSTANDING = txrsa_pkg::MAX_OUTSTANDING
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [txrsa_pkg::CFG_AW-1:0]   paddr,
	input  logic [txrsa_pkg::PDATA_W-1:0]  pwdata,
	output logic [txrsa_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           command,
	input  logic [txrsa_pkg::LEN_W-1:0]    packet_length,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [txrsa_pkg::STATUS_W-1:0] status,
	output logic [txrsa_pkg::OFS_W-1:0]    header_offset,
	output logic [txrsa_pkg::OFS_W-1:0]    data_offset,
	output logic [txrsa_pkg::PAD_W-1:0]    prepad_bytes,
	output logic [txrsa_pkg::PAD_W-1:0]    postpad_bytes,
	output logic [txrsa_pkg::OFS_W-1:0]    next_header_offset,
	output logic [txrsa_pkg::USED_W-1:0]   used_bytes,
	output logic [txrsa_pkg::FREE_W-1:0]   free_bytes
);
	import txrsa_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;

	txrsa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	txrsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	txrsa_dp #(
		.MAX_OUTSTANDING (MAX_OUTSTANDING)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.cmd                (cmd),
		.command            (command),
		.packet_length      (packet_length),
		.status             (status),
		.header_offset      (header_offset),
		.data_offset        (data_offset),
		.prepad_bytes       (prepad_bytes),
		.postpad_bytes      (postpad_bytes),
		.next_header_offset (next_header_offset),
		.used_bytes         (used_bytes),
		.free_bytes         (free_bytes)
	);

endmodule

// ----- verif/tx_packet_ring_slot_allocator_top_tb.sv -----
`timescale 1ns / 1ps
module tx_packet_ring_slot_allocator_top_tb;
	import txrsa_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		status_t             status;
		logic [OFS_W-1:0]    header_offset;
		logic [OFS_W-1:0]    data_offset;
		logic [PAD_W-1:0]    prepad_bytes;
		logic [PAD_W-1:0]    postpad_bytes;
		logic [OFS_W-1:0]    next_header_offset;
		logic [USED_W-1:0]   used_bytes;
		logic [FREE_W-1:0]   free_bytes;
	} slot_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CFG_AW-1:0]   paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic                command = 1'b0;
	logic [LEN_W-1:0]    packet_length = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [OFS_W-1:0]    header_offset;
	logic [OFS_W-1:0]    data_offset;
	logic [PAD_W-1:0]    prepad_bytes;
	logic [PAD_W-1:0]    postpad_bytes;
	logic [OFS_W-1:0]    next_header_offset;
	logic [USED_W-1:0]   used_bytes;
	logic [FREE_W-1:0]   free_bytes;

	// Ring state as the allocator should hold it
	int unsigned ring_page_count;
	int unsigned head_ofs;
	int unsigned free_room;
	int unsigned in_flight;
	int unsigned tail_ofs;
	int unsigned size_fifo [MAX_OUTSTANDING];
	int unsigned rd_ptr;
	int unsigned wr_ptr;

	slot_result_t pending_slots[$];
	bit           idling = 1'b1;
	int unsigned  stall_left = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  errors = 0;
	int unsigned  requests_sent = 0;
	int unsigned  configs_written = 0;
	int unsigned  status_seen [4] = '{0, 0, 0, 0};

	tx_packet_ring_slot_allocator_top u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.command            (command),
		.packet_length      (packet_length),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.header_offset      (header_offset),
		.data_offset        (data_offset),
		.prepad_bytes       (prepad_bytes),
		.postpad_bytes      (postpad_bytes),
		.next_header_offset (next_header_offset),
		.used_bytes         (used_bytes),
		.free_bytes         (free_bytes)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned round_up8(input int unsigned v);
		return (v + 7) & ~32'd7;
	endfunction

	function automatic void reset_ring_state();
		head_ofs  = 0;
		free_room = ring_page_count * PAGE_BYTES - HEADER_BYTES;
		in_flight = 0;
		tail_ofs  = 0;
		rd_ptr    = 0;
		wr_ptr    = 0;
		foreach (size_fifo[i])
			size_fifo[i] = 0;
	endfunction

	// Place a packet or free the oldest one; update the ring state on commit
	function automatic slot_result_t allocate_slot(input command_t cmd,
			input logic [LEN_W-1:0] len_in);
		slot_result_t r;
		int unsigned rb, size, len, tmp_ptr, idx, off, t, nidx, noff;
		int unsigned pre, post, used, doff, nhdr;
		r  = '0;
		rb = ring_page_count * PAGE_BYTES;
		if (cmd == CMD_RELEASE) begin
			r.free_bytes = FREE_W'(free_room);
			if (in_flight == 0) begin
				r.status        = ST_EMPTY;
				r.header_offset = OFS_W'(tail_ofs);
				return r;
			end
			size      = size_fifo[rd_ptr];
			rd_ptr    = (rd_ptr + 1) % MAX_OUTSTANDING;
			in_flight = in_flight - 1;
			free_room = free_room + size;
			r.status             = ST_OK;
			r.header_offset      = OFS_W'(tail_ofs);
			tail_ofs             = (tail_ofs + size) % rb;
			r.next_header_offset = OFS_W'(tail_ofs);
			r.used_bytes         = USED_W'(size);
			r.free_bytes         = FREE_W'(free_room);
			return r;
		end

		len = 32'(len_in);
		r.header_offset = OFS_W'(head_ofs);
		r.free_bytes    = FREE_W'(free_room);
		if (len > PAGE_BYTES - HEADER_BYTES || in_flight >= MAX_OUTSTANDING) begin
			r.status = ST_REJECT;
			return r;
		end

		tmp_ptr = (head_ofs + HEADER_BYTES) % rb;
		idx     = tmp_ptr / PAGE_BYTES;
		off     = tmp_ptr % PAGE_BYTES;
		pre     = 0;
		nidx    = idx;
		t       = round_up8(len + off);
		noff    = t % PAGE_BYTES;
		post    = t - (len + off);
		// keep the next header inside one page; wrap payload to page zero at ring end
		if (t + HEADER_BYTES > PAGE_BYTES) begin
			nidx++;
			if (t <= PAGE_BYTES) begin
				noff = 0;
				post = post + PAGE_BYTES - t;
			end
			if (nidx >= ring_page_count && noff != 0) begin
				noff = round_up8(len);
				nidx = 0;
				pre  = PAGE_BYTES - off;
				post = noff - len;
			end
			nidx = nidx % ring_page_count;
		end
		used = pre + len + post + HEADER_BYTES;
		doff = (tmp_ptr + pre) % rb;
		nhdr = nidx * PAGE_BYTES + noff;

		r.data_offset        = OFS_W'(doff);
		r.prepad_bytes       = PAD_W'(pre);
		r.postpad_bytes      = PAD_W'(post);
		r.next_header_offset = OFS_W'(nhdr);
		r.used_bytes         = USED_W'(used);
		if (used > free_room) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		free_room         = free_room - used;
		in_flight         = in_flight + 1;
		size_fifo[wr_ptr] = used;
		wr_ptr            = (wr_ptr + 1) % MAX_OUTSTANDING;
		head_ofs          = nhdr;
		r.status          = ST_OK;
		r.free_bytes      = FREE_W'(free_room);
		return r;
	endfunction

	task automatic issue_request(input command_t cmd, input logic [LEN_W-1:0] len);
		slot_result_t want;
		if (idling && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid     <= 1'b1;
		command       <= cmd;
		packet_length <= len;
		do @(posedge clk); while (req_stall);
		want = allocate_slot(cmd, len);
		pending_slots.push_back(want);
		requests_sent++;
	endtask

	// Drop valid, wait out every response, then let the pipeline go quiet
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_slots.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_ring(input logic [4:0] pages);
		settle();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= CFG_AW'({REG_RING_PAGES, 2'b00});
		pwdata  <= PDATA_W'(pages);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (pages == 0)
			ring_page_count = 1;
		else if (pages > MAX_PAGES)
			ring_page_count = MAX_PAGES;
		else
			ring_page_count = 32'(pages);
		reset_ring_state();
		configs_written++;
	endtask

	task automatic test_length_extremes();
		issue_request(CMD_RELEASE, '0);
		issue_request(CMD_TX, 13'd0);
		issue_request(CMD_TX, 13'(PAGE_BYTES - HEADER_BYTES));
		issue_request(CMD_TX, 13'(PAGE_BYTES - HEADER_BYTES + 1));
		issue_request(CMD_TX, 13'h1fff);
		issue_request(CMD_TX, 13'(PAGE_BYTES));
		issue_request(CMD_TX, 13'd1);
		issue_request(CMD_TX, 13'd7);
		issue_request(CMD_TX, 13'd4065);
		repeat (5) issue_request(CMD_RELEASE, 13'h1fff);
		issue_request(CMD_TX, 13'd4072);
	endtask

	task automatic test_ring_wrap();
		// zero clamps to a single page
		configure_ring(5'd0);
		issue_request(CMD_TX, 13'd3000);
		issue_request(CMD_TX, 13'd1500);
		issue_request(CMD_RELEASE, '0);
		issue_request(CMD_TX, 13'd1500);
		issue_request(CMD_TX, 13'd2000);
		issue_request(CMD_TX, 13'd2500);
		issue_request(CMD_RELEASE, '0);
		issue_request(CMD_TX, 13'd2550);
		issue_request(CMD_RELEASE, '0);
		issue_request(CMD_RELEASE, '0);
		issue_request(CMD_TX, 13'(PAGE_BYTES - HEADER_BYTES));
	endtask

	task automatic test_table_full();
		configure_ring(5'(MAX_PAGES));
		// offset the FIFO pointers so the fill wraps them
		repeat (20) issue_request(CMD_TX, 13'($urandom_range(0, 48)));
		repeat (20) issue_request(CMD_RELEASE, 13'($urandom));
		while (in_flight < MAX_OUTSTANDING)
			issue_request(CMD_TX, 13'($urandom_range(0, 48)));
		issue_request(CMD_TX, 13'd0);
		repeat (10) issue_request(CMD_RELEASE, 13'($urandom));
	endtask

	task automatic test_random_traffic();
		logic [4:0]  sizes [8];
		int unsigned pick, release_pct;
		logic [LEN_W-1:0] len;
		sizes = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd3, 5'd0, 5'd8, 5'd17};
		sizes[5] = 5'($urandom_range(1, MAX_PAGES));
		for (int p = 0; p < 8; p++) begin
			configure_ring(sizes[p]);
			idling = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 24; n++) begin
				// fill first, then lean toward draining
				release_pct = (n < 12) ? 25 : 60;
				if ($urandom_range(0, 99) < release_pct) begin
					issue_request(CMD_RELEASE, 13'($urandom));
				end else begin
					pick = $urandom_range(0, 19);
					if (pick < 13)
						len = 13'($urandom_range(0, PAGE_BYTES - HEADER_BYTES));
					else if (pick < 15)
						len = 13'($urandom_range(PAGE_BYTES - HEADER_BYTES - 40,
							PAGE_BYTES - HEADER_BYTES));
					else if (pick < 18)
						len = 13'($urandom_range(0, 24));
					else
						len = 13'($urandom_range(PAGE_BYTES - HEADER_BYTES + 1, 8191));
					issue_request(CMD_TX, len);
				end
			end
		end
	endtask

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : rsp_check
		slot_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_slots.size() == 0) begin
				$display("%0t: response with no request outstanding, status %0d",
					$time, status);
				errors++;
			end else begin
				want = pending_slots.pop_front();
				status_seen[status]++;
				check_field("status", 32'(want.status), 32'(status));
				check_field("header_offset", 32'(want.header_offset),
					32'(header_offset));
				check_field("data_offset", 32'(want.data_offset), 32'(data_offset));
				check_field("prepad_bytes", 32'(want.prepad_bytes), 32'(prepad_bytes));
				check_field("postpad_bytes", 32'(want.postpad_bytes),
					32'(postpad_bytes));
				check_field("next_header_offset", 32'(want.next_header_offset),
					32'(next_header_offset));
				check_field("used_bytes", 32'(want.used_bytes), 32'(used_bytes));
				check_field("free_bytes", 32'(want.free_bytes), 32'(free_bytes));
			end
		end
	end

	// Output backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d responses outstanding",
				$time, WATCHDOG_LIMIT, pending_slots.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		ring_page_count = MAX_PAGES;
		reset_ring_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_extremes();
		test_ring_wrap();
		test_table_full();
		test_random_traffic();
		settle();

		$display("Checked %0d requests over %0d ring size writes",
			requests_sent, configs_written);
		$display("Statuses seen: ok %0d, no space %0d, empty %0d, rejected %0d",
			status_seen[ST_OK], status_seen[ST_NO_SPACE],
			status_seen[ST_EMPTY], status_seen[ST_REJECT]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
